@@ rtl/core/huffman_code_builder_macros.svh @@
// assertion macros shared by the huffman code builder rtl
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define HCB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define HCB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HCB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define HCB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/hcb_pkg.sv @@
// types, codes and defaults shared by the huffman code builder
`timescale 1ns / 1ps
package hcb_pkg;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = 32;
  localparam int CODE_W = 64;
  localparam int LEN_W  = 7;
  localparam int LIVE_W = 9;

  localparam int SYMBOLS_DEF       = 256;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int MAX_CODE_BITS_DEF = 64;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_INIT  = 3'd3;
  localparam logic [2:0] OP_MERGE = 3'd4;

  // token handed from cell to cell
  typedef struct packed {
    logic [2:0]        op;
    logic [SYM_W-1:0]  sym;
    logic [CNT_W-1:0]  cnt;     // load count, or merged weight of second group
    logic [SYM_W-1:0]  first;
    logic [SYM_W-1:0]  second;
    logic              m1v;
    logic [SYM_W-1:0]  m1i;
    logic [CNT_W-1:0]  m1w;
    logic              m2v;
    logic [SYM_W-1:0]  m2i;
    logic [CNT_W-1:0]  m2w;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [LIVE_W-1:0] live;
    logic              ovf;
  } tok_t;
endpackage

@@ rtl/core/huffman_code_builder.sv @@
// huffman code builder top level: cell chain and build sequencing
`timescale 1ns / 1ps
// usage
// - input words (s_*): tuser carries the command (load count, build, read code),
//   tdata the symbol and count; loads give no output word, builds and reads one
// - output words (m_*): code bits, code length, used symbol count, overflow flag
// - every command travels as a token through a row of SYMBOLS cells, one per
//   symbol, one cell per cycle while not held; each holds that symbol's state
// - load and read: one word per cycle when not held or building; a read result
//   passes all cells, then the output register; loads and reads keep order
// - build: the block stops taking words; a first pass clears the codes and
//   finds the two lightest groups, then each merge is one more pass that adds
//   the code bits and finds the next pair, until at most one group is left
// - a merged weight saturates at COUNT_BITS bits and a code stops at
//   MAX_CODE_BITS bits; either sets the overflow flag of that build
// - reset (rst, synchronous) zeroes all counts and lengths, no build needed
// - when the receiver stalls, the whole chain holds and s_tready drops until
//   the held output word is taken, so nothing is lost
`include "huffman_code_builder_macros.svh"
module huffman_code_builder #(
  parameter int SYMBOLS       = hcb_pkg::SYMBOLS_DEF,
  parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // symbol[7:0], count[39:8]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // code_bits[63:0], code_length[70:64],
                                 // used_symbols[79:71], overflow[80], zero fill
);
  import hcb_pkg::*;

  // largest group weight
  localparam logic [CNT_W:0] WMAX = (CNT_W+1)'((64'(1) << COUNT_BITS) - 64'(1));

  tok_t              link [SYMBOLS+1];
  tok_t              head;
  tok_t              tail;
  logic              adv;
  logic              in_acc;
  logic              busy;
  logic              ovf;
  logic [LIVE_W-1:0] live;
  logic [CNT_W:0]    sum;
  logic              sat;
  logic              build_tok;
  logic              more;
  logic              ovf_all;
  logic [LIVE_W-1:0] live_all;

  // output register
  logic [CODE_W-1:0] o_code;
  logic [LEN_W-1:0]  o_len;
  logic [LIVE_W-1:0] o_used;
  logic              o_ovf;

  // the chain only moves when the output register can take a word
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !busy;
  assign in_acc   = s_tvalid && s_tready;
  assign tail     = link[SYMBOLS];

  assign sum       = {1'b0, tail.m1w} + {1'b0, tail.m2w};
  assign sat       = sum > WMAX;
  assign build_tok = (tail.op == OP_INIT) || (tail.op == OP_MERGE);
  assign more      = build_tok && tail.m1v && tail.m2v;
  // the flag and the symbol count restart when the first pass comes out
  assign ovf_all   = ((tail.op == OP_INIT) ? 1'b0 : ovf) | tail.ovf;
  assign live_all  = (tail.op == OP_INIT) ? tail.live : live;

  always_comb begin
    head = '0;
    if (adv && more) begin
      head.op     = OP_MERGE;
      head.first  = tail.m1i;
      head.second = tail.m2i;
      head.cnt    = sat ? WMAX[CNT_W-1:0] : sum[CNT_W-1:0];
    end else if (in_acc) begin
      head.sym = s_tdata[7:0];
      head.cnt = s_tdata[39:8];
      unique case (s_tuser)
        CMD_LOAD:  head.op = OP_LOAD;
        CMD_BUILD: head.op = OP_INIT;
        CMD_READ:  head.op = OP_READ;
        default:   head.op = OP_NONE;
      endcase
    end
  end

  assign link[0] = head;

  for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
    hcb_cell #(
      .IDX           (i),
      .COUNT_BITS    (COUNT_BITS),
      .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      ovf      <= 1'b0;
      live     <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      if (in_acc && s_tuser == CMD_BUILD) busy <= 1'b1;
      if (build_tok) begin
        ovf  <= ovf_all | (more && sat);
        live <= live_all;
      end
      if ((build_tok && !more) || tail.op == OP_READ) begin
        m_tvalid <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
      if (build_tok && !more) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (build_tok && !more) begin
        o_code <= '0;
        o_len  <= '0;
        o_used <= live_all;
        o_ovf  <= ovf_all;
      end else if (tail.op == OP_READ) begin
        o_code <= tail.code;
        o_len  <= tail.len;
        o_used <= live;
        o_ovf  <= ovf;
      end
    end
  end

  assign m_tdata = {7'b0, o_ovf, o_used, o_len, o_code};

  `HCB_ASSERT_IMP(a_no_take_in_build, clk, rst, busy, !s_tready, "word taken during build")
  `HCB_ASSERT_NXT(a_read_gives_word, clk, rst, adv && tail.op == OP_READ, m_tvalid, "read lost")
  `HCB_ASSERT_IMP(a_merge_in_build, clk, rst, tail.op == OP_MERGE, busy, "merge outside build")
endmodule

@@ rtl/core/hcb_cell.sv @@
// one symbol cell: weight, group, code and group weight of one symbol
`timescale 1ns / 1ps
module hcb_cell #(
  parameter int IDX           = 0,
  parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  hcb_pkg::tok_t tok_in,
  output hcb_pkg::tok_t tok_out
);
  import hcb_pkg::*;

  logic [COUNT_BITS-1:0]    w, w_next;
  logic [LEN_W-1:0]         len, len_next;
  logic [MAX_CODE_BITS-1:0] code, code_next;
  logic [SYM_W-1:0]         grp, grp_next;
  logic                     alive, alive_next;
  logic [COUNT_BITS-1:0]    gw, gw_next;
  tok_t                     tok_next;
  logic                     used;
  logic                     add_en;
  logic                     add_bit;
  logic [CNT_W-1:0]         wx;
  logic [SYM_W-1:0]         my_idx;

  assign my_idx = SYM_W'(IDX);
  assign used   = (w != '0);

  always_comb begin
    tok_next   = tok_in;
    w_next     = w;
    len_next   = len;
    code_next  = code;
    grp_next   = grp;
    alive_next = alive;
    gw_next    = gw;
    add_en     = 1'b0;
    add_bit    = 1'b0;
    wx         = '0;
    unique case (tok_in.op)
      OP_LOAD: begin
        if (tok_in.sym == my_idx) w_next = tok_in.cnt[COUNT_BITS-1:0];
      end
      OP_READ: begin
        if (tok_in.sym == my_idx && len != '0) begin
          tok_next.code = CODE_W'(code);
          tok_next.len  = len;
        end
      end
      OP_INIT: begin
        code_next  = '0;
        len_next   = '0;
        alive_next = used;
        gw_next    = w;
        grp_next   = my_idx;
        if (used) tok_next.live = tok_in.live + LIVE_W'(1);
      end
      OP_MERGE: begin
        if (used && grp == tok_in.first) begin
          add_en   = 1'b1;
          add_bit  = 1'b0;
          grp_next = tok_in.second;
        end else if (used && grp == tok_in.second) begin
          add_en  = 1'b1;
          add_bit = 1'b1;
        end
        if (my_idx == tok_in.first) begin
          alive_next = 1'b0;
          gw_next    = '0;
        end
        if (my_idx == tok_in.second) gw_next = tok_in.cnt[COUNT_BITS-1:0];
      end
      default: begin
      end
    endcase
    // one bit at the root end of the code
    if (add_en) begin
      if (len >= LEN_W'(MAX_CODE_BITS)) begin
        tok_next.ovf = 1'b1;
      end else begin
        code_next = code | (MAX_CODE_BITS'(add_bit) << len);
        len_next  = len + LEN_W'(1);
      end
    end
    // running two-minimum search, ties to the higher index
    if ((tok_in.op == OP_INIT || tok_in.op == OP_MERGE) && alive_next) begin
      wx = CNT_W'(gw_next);
      if (!tok_in.m1v || wx <= tok_in.m1w) begin
        tok_next.m2v = tok_in.m1v;
        tok_next.m2i = tok_in.m1i;
        tok_next.m2w = tok_in.m1w;
        tok_next.m1v = 1'b1;
        tok_next.m1i = my_idx;
        tok_next.m1w = wx;
      end else if (!tok_in.m2v || wx <= tok_in.m2w) begin
        tok_next.m2v = 1'b1;
        tok_next.m2i = my_idx;
        tok_next.m2w = wx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w       <= '0;
      len     <= '0;
      tok_out <= '0;
    end else if (adv) begin
      w       <= w_next;
      len     <= len_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code  <= code_next;
      grp   <= grp_next;
      alive <= alive_next;
      gw    <= gw_next;
    end
  end
endmodule
